### rtl/aes192_pkg.sv
// ----------------------------------------------------------------------------
// AES-192 package
// Shared types, constants and round functions for the AES-192 cipher block.
// ----------------------------------------------------------------------------
`default_nettype none
package aes192_pkg;

   localparam int TOTAL_WORDS = 52;
   localparam int KEY_WORDS   = 6;
   localparam int LAST_ROUND  = 12;

   localparam logic [1:0] CSR_KEY0 = 2'd0;
   localparam logic [1:0] CSR_KEY1 = 2'd1;
   localparam logic [1:0] CSR_KEY2 = 2'd2;
   localparam logic [1:0] CSR_MODE = 2'd3;

   typedef logic [127:0] state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_key;   // load the 6 key words
      logic       key_step;   // produce next round-key word
      logic [5:0] key_idx;    // index of word being produced
      logic       load_blk;   // load block and xor first round key
      logic       rnd_step;   // one cipher round
      logic       rnd_last;   // final round (no mix)
      logic       decrypt;
      logic [3:0] rnd_key;    // round-key number used in this step
      logic       out_load;
   } cmd_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

   localparam logic [7:0] RCON [8] = '{8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80};

   function automatic logic [7:0] inv_sbox(input logic [7:0] v);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 256; i++)
         if (SBOX[i] == v) r = i[7:0];
      return r;
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   // byte n of the state (byte 0 in the top bits)
   function automatic logic [7:0] sb(input state_type s, input int n);
      return s[127 - 8*n -: 8];
   endfunction

   function automatic state_type enc_round(input state_type s, input logic last);
      state_type t, m;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8*(r + 4*c) -: 8] = SBOX[sb(s, r + 4*((c + r) & 3))];
      m = t;
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = sb(t, 4*c); a1 = sb(t, 4*c+1); a2 = sb(t, 4*c+2); a3 = sb(t, 4*c+3);
            m[127 - 8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            m[127 - 8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            m[127 - 8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            m[127 - 8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
         end
      end
      return m;
   endfunction

   function automatic state_type inv_shift_sub(input state_type s);
      state_type t;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8*(r + 4*((c + r) & 3)) -: 8] = inv_sbox(sb(s, r + 4*c));
      return t;
   endfunction

   function automatic state_type inv_mix(input state_type s);
      state_type m;
      logic [7:0] a0, a1, a2, a3;
      logic [7:0] b0, b1, b2, b3, c0, c1, c2, c3, d0, d1, d2, d3;
      for (int c = 0; c < 4; c++) begin
         a0 = sb(s, 4*c); a1 = sb(s, 4*c+1); a2 = sb(s, 4*c+2); a3 = sb(s, 4*c+3);
         b0 = xt(a0); b1 = xt(a1); b2 = xt(a2); b3 = xt(a3);
         c0 = xt(b0); c1 = xt(b1); c2 = xt(b2); c3 = xt(b3);
         d0 = xt(c0); d1 = xt(c1); d2 = xt(c2); d3 = xt(c3);
         // 14 = 8+4+2, 11 = 8+2+1, 13 = 8+4+1, 9 = 8+1
         m[127 - 8*(4*c)   -: 8] = (d0^c0^b0) ^ (d1^b1^a1) ^ (d2^c2^a2) ^ (d3^a3);
         m[127 - 8*(4*c+1) -: 8] = (d0^a0) ^ (d1^c1^b1) ^ (d2^b2^a2) ^ (d3^c3^a3);
         m[127 - 8*(4*c+2) -: 8] = (d0^c0^a0) ^ (d1^a1) ^ (d2^c2^b2) ^ (d3^b3^a3);
         m[127 - 8*(4*c+3) -: 8] = (d0^b0^a0) ^ (d1^c1^a1) ^ (d2^a2) ^ (d3^c3^b3);
      end
      return m;
   endfunction

endpackage
`default_nettype wire

### rtl/aes192_stream_if.sv
// ----------------------------------------------------------------------------
// AES-192 stream interface
// Valid/ready channel carrying one 128-bit block as two 64-bit halves.
// ----------------------------------------------------------------------------
`default_nettype none
interface aes192_stream_if;
   logic        valid;
   logic        ready;
   logic [63:0] hi;
   logic [63:0] lo;
   modport source (output valid, output hi, output lo, input ready);
   modport sink   (input valid, input hi, input lo, output ready);
endinterface
`default_nettype wire

### rtl/aes192_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-192 block cipher
// ECB AES-192 encrypt/decrypt engine with a one-round-per-cycle datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - write key words 0..2 and the mode through the csr_ port while idle
//  - blocks enter on req_ (valid/ready), results leave on rsp_ (valid/ready)
//  - after reset or a key write the first block waits for key expansion,
//    which makes one round-key word per cycle through the key schedule
//  - each block then goes through one key add on entry, twelve rounds
//    through the shared round unit, and a move into the result register
//  - the result register holds a beat until rsp_ready; the engine may accept
//    and process the next block meanwhile, and waits only to hand it over
//  - reset clears all control state; the round-key memory is refilled on
//    the next expansion
// ----------------------------------------------------------------------------
`default_nettype none
module aes192_block_cipher
   import aes192_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   aes192_stream_if.sink     req,
   aes192_stream_if.source   rsp,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [63:0]  csr_wdata
);
   logic [63:0] key0_ff, key1_ff, key2_ff;
   logic        mode_ff, stale_ff, ovalid_ff;
   cmd_type     cmd;
   logic        in_ready;
   logic [127:0] result;
   logic        key_wr;

   assign key_wr = csr_we && (csr_index == CSR_KEY0 || csr_index == CSR_KEY1 ||
                              csr_index == CSR_KEY2);

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0; key1_ff <= '0; key2_ff <= '0;
         mode_ff <= 1'b0; stale_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_KEY0) key0_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_KEY1) key1_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_KEY2) key2_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_MODE) mode_ff <= csr_wdata[0];
         // stale holds for one cycle so the controller drops ready_ff
         stale_ff <= key_wr;
         if (cmd.out_load) ovalid_ff <= 1'b1;
         else if (rsp.ready) ovalid_ff <= 1'b0;
      end
   end

   aes192_ctrl u_ctrl (
      .clock, .reset,
      .keys_stale (stale_ff | key_wr),
      .mode       (mode_ff),
      .in_valid   (req.valid),
      .in_ready,
      .out_busy   (ovalid_ff & ~rsp.ready),
      .cmd
   );

   aes192_dpath u_dpath (
      .clock,
      .key    ({key0_ff, key1_ff, key2_ff}),
      .cmd,
      .blk    ({req.hi, req.lo}),
      .result
   );

   assign req.ready = in_ready;
   assign rsp.valid = ovalid_ff;
   assign rsp.hi    = result[127:64];
   assign rsp.lo    = result[63:0];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.hi))
      else $error("result changed while stalled");
   a_noaccept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.rnd_step |-> !req.ready)
      else $error("block accepted mid-round");
   a_keyx_blocks: assert property (@(posedge clock) disable iff (reset)
      cmd.key_step |-> !req.ready)
      else $error("block accepted during key expansion");
endmodule
`default_nettype wire

### rtl/aes192_ctrl.sv
// ----------------------------------------------------------------------------
// AES-192 controller
// Sequences key expansion, the twelve rounds and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module aes192_ctrl
   import aes192_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    keys_stale,   // key word written
   input  wire logic    mode,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire logic    out_busy,     // result register still full
   output cmd_type      cmd
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_KEYX = 2'd1;
   localparam logic [1:0] ST_RND  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [5:0] kidx_ff, kidx_in;
   logic [3:0] rnd_ff, rnd_in;
   logic       ready_ff, ready_in;
   logic       dec_ff, dec_in;

   always_comb begin
      state_in = state_ff;
      kidx_in  = kidx_ff;
      rnd_in   = rnd_ff;
      ready_in = ready_ff & ~keys_stale;
      dec_in   = dec_ff;
      cmd      = '0;
      cmd.decrypt = dec_ff;
      cmd.key_idx = kidx_ff;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = ready_ff & ~keys_stale;
            if (!(ready_ff & ~keys_stale)) begin
               cmd.load_key = 1'b1;
               kidx_in  = 6'(KEY_WORDS);
               state_in = ST_KEYX;
            end else if (in_valid) begin
               cmd.load_blk = 1'b1;
               cmd.decrypt  = mode;
               cmd.rnd_key  = mode ? 4'(LAST_ROUND) : 4'd0;
               dec_in   = mode;
               rnd_in   = 4'd1;
               state_in = ST_RND;
            end
         end
         ST_KEYX: begin
            // a key write during expansion starts it again from the new key
            if (keys_stale) begin
               state_in = ST_IDLE;
            end else begin
               cmd.key_step = 1'b1;
               kidx_in = kidx_ff + 6'd1;
               if (kidx_ff == 6'(TOTAL_WORDS - 1)) begin
                  ready_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RND: begin
            cmd.rnd_step = 1'b1;
            cmd.rnd_last = (rnd_ff == 4'(LAST_ROUND));
            cmd.rnd_key  = dec_ff ? 4'(LAST_ROUND) - rnd_ff : rnd_ff;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'(LAST_ROUND)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_busy) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         kidx_ff  <= '0;
         rnd_ff   <= '0;
         dec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         kidx_ff  <= kidx_in;
         rnd_ff   <= rnd_in;
         dec_ff   <= dec_in;
      end
   end
endmodule
`default_nettype wire

### rtl/aes192_dpath.sv
// ----------------------------------------------------------------------------
// AES-192 datapath
// Round-key memory, key schedule, round unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module aes192_dpath
   import aes192_pkg::*;
(
   input  wire logic          clock,
   input  wire logic [191:0]  key,
   input  wire cmd_type       cmd,
   input  wire logic [127:0]  blk,
   output logic [127:0]       result
);
   // round keys kept as 13 rows of four words; expansion fills one word per cycle
   logic [127:0] rk_ff [LAST_ROUND+1];
   logic [31:0]  win_ff [KEY_WORDS];   // sliding window of the last six words
   logic [2:0]   kmod_ff;              // place of the next word in its group of six
   logic [2:0]   rc_ff;
   logic [31:0]  t, nw;
   state_type    st_ff, st_in, rkey, tmp;
   logic [127:0] res_ff;

   always_comb begin
      t = win_ff[KEY_WORDS-1];
      if (kmod_ff == 3'd0) begin
         t = {t[23:0], t[31:24]};
         t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
         t = t ^ {RCON[rc_ff], 24'h0};
      end
      nw = win_ff[0] ^ t;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         for (int i = 0; i < KEY_WORDS; i++) begin
            win_ff[i] <= key[191 - 32*i -: 32];
         end
         kmod_ff <= 3'd0;
         rc_ff   <= 3'd0;
         rk_ff[0]         <= key[191:64];
         rk_ff[1][127:64] <= key[63:0];
      end else if (cmd.key_step) begin
         for (int i = 0; i < KEY_WORDS-1; i++) win_ff[i] <= win_ff[i+1];
         win_ff[KEY_WORDS-1] <= nw;
         kmod_ff <= (kmod_ff == 3'(KEY_WORDS-1)) ? 3'd0 : kmod_ff + 3'd1;
         if (kmod_ff == 3'd0) rc_ff <= rc_ff + 3'd1;
         rk_ff[cmd.key_idx[5:2]][127 - 32*cmd.key_idx[1:0] -: 32] <= nw;
      end
   end

   always_comb begin
      rkey  = rk_ff[cmd.rnd_key];
      st_in = st_ff;
      tmp   = '0;
      if (cmd.load_blk) begin
         st_in = blk ^ rkey;
      end else if (cmd.rnd_step) begin
         if (cmd.decrypt) begin
            tmp   = inv_shift_sub(st_ff) ^ rkey;
            st_in = cmd.rnd_last ? tmp : inv_mix(tmp);
         end else begin
            st_in = enc_round(st_ff, cmd.rnd_last) ^ rkey;
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (cmd.out_load) res_ff <= st_ff;
   end

   assign result = res_ff;
endmodule
`default_nettype wire
